>>> sv/tlt_pkg.sv
// shared constants, result type and helper functions of the tag list line tokenizer
package tlt_pkg;

  localparam int unsigned MaxPending = 16;
  localparam int unsigned CntW       = $clog2(MaxPending + 1);
  localparam int unsigned AddrW      = (MaxPending > 1) ? $clog2(MaxPending) : 1;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QAddrW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [1:0] KindByte = 2'd0;
  localparam logic [1:0] KindEnd  = 2'd1;
  localparam logic [1:0] KindRec  = 2'd2;
  localparam logic [1:0] KindErr  = 2'd3;

  localparam logic [1:0] SepNone  = 2'd0;
  localparam logic [1:0] SepComma = 2'd1;
  localparam logic [1:0] SepColon = 2'd2;

  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrSepEnds   = 3'd1;
  localparam logic [2:0] ErrLeadSep   = 3'd2;
  localparam logic [2:0] ErrDoubleSep = 3'd3;
  localparam logic [2:0] ErrNoItems   = 3'd4;
  localparam logic [2:0] ErrColon2    = 3'd5;
  localparam logic [2:0] ErrOverflow  = 3'd6;

  localparam logic [1:0] PendSpace = 2'd0;
  localparam logic [1:0] PendTab   = 2'd1;
  localparam logic [1:0] PendColon = 2'd2;
  localparam logic [1:0] PendComma = 2'd3;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChColon   = 8'h3a;
  localparam logic [7:0] ChComma   = 8'h2c;
  localparam logic [7:0] ChNewline = 8'h0a;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       is_tag;
    logic [1:0] separator;
    logic       record_has_tags;
    logic [2:0] error_code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic            busy;
    logic            halted;
    logic [CntW-1:0] pend_cnt;
  } front_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [7:0] ch, logic tag,
                                  logic [1:0] sep, logic rht, logic [2:0] err);
    res_t r;
    r.kind            = kind;
    r.char_out        = ch;
    r.is_tag          = tag;
    r.separator       = sep;
    r.record_has_tags = rht;
    r.error_code      = err;
    r.last            = 1'b0;
    return r;
  endfunction

  function automatic logic [1:0] code_of(logic [7:0] c);
    logic [1:0] code;
    if (c == ChSpace) begin
      code = PendSpace;
    end else if (c == ChTab) begin
      code = PendTab;
    end else if (c == ChColon) begin
      code = PendColon;
    end else begin
      code = PendComma;
    end
    return code;
  endfunction

  function automatic logic [7:0] char_of(logic [1:0] code);
    logic [7:0] c;
    case (code)
      PendSpace: c = ChSpace;
      PendTab:   c = ChTab;
      PendColon: c = ChColon;
      default:   c = ChComma;
    endcase
    return c;
  endfunction

endpackage

>>> sv/tlt_if.sv
// valid/ready channel interfaces for input bytes and result beats
interface tlt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_stream;

  modport source (output valid, output char_in, output end_of_stream, input ready);
  modport sink   (input valid, input char_in, input end_of_stream, output ready);
endinterface

interface tlt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic       is_tag;
  logic [1:0] separator;
  logic       record_has_tags;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output kind, output char_out, output is_tag,
                  output separator, output record_has_tags, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input char_out, input is_tag,
                  input separator, input record_has_tags, input error_code,
                  input last, output ready);
endinterface

>>> sv/tlt_front.sv
// front: classifies input bytes, keeps scan state and pending store, sequences results
module tlt_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tlt_in_if.sink                in_i,
  output tlt_pkg::res_t         push_data_o,
  output logic                  push_o,
  input  logic                  full_i,
  output tlt_pkg::front_stat_t  stat_o
);
  import tlt_pkg::*;

  localparam logic [2:0] StLead  = 3'd0;
  localparam logic [2:0] StElem  = 3'd1;
  localparam logic [2:0] StBlank = 3'd2;
  localparam logic [2:0] StSeps  = 3'd3;
  localparam logic [2:0] StTrail = 3'd4;

  localparam logic SeqIdle = 1'b0;
  localparam logic SeqRun  = 1'b1;

  logic [2:0]      st_q, st_d;
  logic [1:0]      hs_q, hs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            tag_q, tag_d;
  logic            items_q, items_d;
  logic            tags_q, tags_d;
  logic            halt_q, halt_d;

  logic            seq_q, seq_d;
  logic [CntW-1:0] fl_idx_q, fl_idx_d;
  logic [CntW-1:0] fl_n_q, fl_n_d;
  logic            fix_idx_q, fix_idx_d;
  logic            fl_tag_q;
  res_t            r0_q, r1_q, r0_d, r1_d;
  logic [1:0]      rdata_q;
  logic [1:0]      pend_mem [MaxPending];

  logic            accept;
  logic [CntW-1:0] flush_n;
  logic [1:0]      nres;
  logic            push_req;
  logic            wen;
  logic            fl_more;
  logic [7:0]      c;
  logic            is_blank, is_sep;
  logic            ended, it, tg;
  res_t            rr;

  assign in_i.ready = (seq_q == SeqIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.char_in;
  assign is_blank   = (c == ChSpace) || (c == ChTab);
  assign is_sep     = (c == ChColon) || (c == ChComma);

  always_comb begin
    st_d     = st_q;
    hs_d     = hs_q;
    cnt_d    = cnt_q;
    tag_d    = tag_q;
    items_d  = items_q;
    tags_d   = tags_q;
    halt_d   = halt_q;
    r0_d     = mk_res(KindByte, 8'd0, 1'b0, SepNone, 1'b0, ErrNone);
    r1_d     = r0_d;
    nres     = 2'd0;
    flush_n  = '0;
    push_req = 1'b0;
    wen      = 1'b0;
    ended    = 1'b0;
    it       = 1'b0;
    tg       = 1'b0;
    rr       = r0_d;
    if (!halt_q) begin
      if (in_i.end_of_stream || c == ChNewline) begin
        if (!in_i.end_of_stream && hs_q == SepComma) begin
          r0_d   = mk_res(KindErr, 8'd0, 1'b0, SepNone, 1'b0, ErrSepEnds);
          nres   = 2'd1;
          halt_d = 1'b1;
        end else begin
          ended = (st_q != StLead);
          it    = items_q | (ended & ~tag_q);
          tg    = tags_q | (ended & tag_q);
          if (ended) begin
            r0_d = mk_res(KindEnd, 8'd0, tag_q, SepNone, 1'b0, ErrNone);
            nres = 2'd1;
          end
          if (it || tg) begin
            if (!it) begin
              rr     = mk_res(KindErr, 8'd0, 1'b0, SepNone, 1'b0, ErrNoItems);
              halt_d = 1'b1;
            end else begin
              rr = mk_res(KindRec, 8'd0, 1'b0, SepNone, tg, ErrNone);
            end
            if (ended) begin
              r1_d = rr;
            end else begin
              r0_d = rr;
            end
            nres = nres + 2'd1;
          end
          st_d    = StLead;
          hs_d    = SepNone;
          cnt_d   = '0;
          tag_d   = 1'b0;
          items_d = 1'b0;
          tags_d  = 1'b0;
        end
      end else begin
        case (st_q)
          StElem: begin
            if (is_blank) begin
              push_req = 1'b1;
              st_d     = StBlank;
            end else if (is_sep) begin
              hs_d     = (c == ChComma) ? SepComma : SepColon;
              push_req = 1'b1;
              st_d     = StSeps;
            end else begin
              r0_d = mk_res(KindByte, c, tag_q, SepNone, 1'b0, ErrNone);
              nres = 2'd1;
            end
          end
          StBlank: begin
            if (is_blank) begin
              push_req = 1'b1;
            end else if (is_sep) begin
              hs_d = (c == ChComma) ? SepComma : SepColon;
              st_d = StTrail;
            end else begin
              flush_n = cnt_q;
              r0_d    = mk_res(KindByte, c, tag_q, SepNone, 1'b0, ErrNone);
              nres    = 2'd1;
              cnt_d   = '0;
              hs_d    = SepNone;
              st_d    = StElem;
            end
          end
          StSeps: begin
            if (is_blank) begin
              if (cnt_q > CntW'(1)) begin
                r0_d   = mk_res(KindErr, 8'd0, 1'b0, SepNone, 1'b0, ErrDoubleSep);
                nres   = 2'd1;
                halt_d = 1'b1;
              end else begin
                st_d = StTrail;
              end
            end else if (is_sep) begin
              push_req = 1'b1;
            end else begin
              flush_n = cnt_q;
              r0_d    = mk_res(KindByte, c, tag_q, SepNone, 1'b0, ErrNone);
              nres    = 2'd1;
              cnt_d   = '0;
              hs_d    = SepNone;
              st_d    = StElem;
            end
          end
          StTrail: begin
            if (!is_blank) begin
              r0_d = mk_res(KindEnd, 8'd0, tag_q, hs_q, 1'b0, ErrNone);
              nres = 2'd1;
              if (tag_q) begin
                tags_d = 1'b1;
              end else begin
                items_d = 1'b1;
              end
              st_d  = StLead;
              hs_d  = SepNone;
              cnt_d = '0;
              if (hs_q == SepColon && tag_q) begin
                r1_d   = mk_res(KindErr, 8'd0, 1'b0, SepNone, 1'b0, ErrColon2);
                nres   = 2'd2;
                halt_d = 1'b1;
              end else begin
                if (hs_q == SepColon) begin
                  tag_d = 1'b1;
                end
                nres = 2'd2;
                if (is_sep) begin
                  r1_d   = mk_res(KindErr, 8'd0, 1'b0, SepNone, 1'b0, ErrLeadSep);
                  halt_d = 1'b1;
                end else begin
                  r1_d = mk_res(KindByte, c, tag_d, SepNone, 1'b0, ErrNone);
                  st_d = StElem;
                end
              end
            end
          end
          default: begin
            if (is_sep) begin
              r0_d   = mk_res(KindErr, 8'd0, 1'b0, SepNone, 1'b0, ErrLeadSep);
              nres   = 2'd1;
              halt_d = 1'b1;
            end else if (!is_blank) begin
              r0_d = mk_res(KindByte, c, tag_q, SepNone, 1'b0, ErrNone);
              nres = 2'd1;
              st_d = StElem;
            end
          end
        endcase
        if (push_req) begin
          if (cnt_q >= CntW'(MaxPending)) begin
            r0_d   = mk_res(KindErr, 8'd0, 1'b0, SepNone, 1'b0, ErrOverflow);
            nres   = 2'd1;
            halt_d = 1'b1;
          end else begin
            wen   = 1'b1;
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end
    end
    r0_d.last = (nres == 2'd1);
    r1_d.last = (nres == 2'd2);
  end

  // result sequencer: pending bytes first, then the fixed results
  assign fl_more = (fl_idx_q != fl_n_q);

  always_comb begin
    push_o      = 1'b0;
    push_data_o = fix_idx_q ? r1_q : r0_q;
    seq_d       = seq_q;
    fl_idx_d    = fl_idx_q;
    fl_n_d      = fl_n_q;
    fix_idx_d   = fix_idx_q;
    if (accept) begin
      fl_idx_d  = '0;
      fl_n_d    = flush_n;
      fix_idx_d = 1'b0;
      seq_d     = (nres != 2'd0) ? SeqRun : SeqIdle;
    end else if (seq_q == SeqRun && !full_i) begin
      push_o = 1'b1;
      if (fl_more) begin
        push_data_o = mk_res(KindByte, char_of(rdata_q), fl_tag_q, SepNone, 1'b0, ErrNone);
        fl_idx_d    = fl_idx_q + CntW'(1);
      end else begin
        fix_idx_d = 1'b1;
        if (push_data_o.last) begin
          seq_d = SeqIdle;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StLead;
      hs_q      <= SepNone;
      cnt_q     <= '0;
      tag_q     <= 1'b0;
      items_q   <= 1'b0;
      tags_q    <= 1'b0;
      halt_q    <= 1'b0;
      seq_q     <= SeqIdle;
      fl_idx_q  <= '0;
      fl_n_q    <= '0;
      fix_idx_q <= 1'b0;
    end else begin
      if (accept) begin
        st_q    <= st_d;
        hs_q    <= hs_d;
        cnt_q   <= cnt_d;
        tag_q   <= tag_d;
        items_q <= items_d;
        tags_q  <= tags_d;
        halt_q  <= halt_d;
      end
      seq_q     <= seq_d;
      fl_idx_q  <= fl_idx_d;
      fl_n_q    <= fl_n_d;
      fix_idx_q <= fix_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      r0_q     <= r0_d;
      r1_q     <= r1_d;
      fl_tag_q <= tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && wen) begin
      pend_mem[cnt_q[AddrW-1:0]] <= code_of(c);
    end
    rdata_q <= pend_mem[fl_idx_d[AddrW-1:0]];
  end

  assign stat_o.busy     = (seq_q == SeqRun);
  assign stat_o.halted   = halt_q;
  assign stat_o.pend_cnt = cnt_q;

endmodule

>>> sv/tlt_queue.sv
// short result queue between front and back
module tlt_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tlt_pkg::res_t         push_data_i,
  input  logic                  pop_i,
  output tlt_pkg::res_t         pop_data_o,
  output tlt_pkg::queue_stat_t  stat_o
);
  import tlt_pkg::*;

  res_t              q_mem [QueueDepth];
  logic [QAddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QAddrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QAddrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QAddrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QAddrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/tlt_back.sv
// back: output register that drives result beats onto the output channel
module tlt_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tlt_pkg::res_t         pop_data_i,
  input  tlt_pkg::queue_stat_t  q_stat_i,
  output logic                  pop_o,
  tlt_out_if.source             out_o
);
  import tlt_pkg::*;

  logic vld_q;
  res_t res_q;

  assign pop_o = !q_stat_i.empty && (!vld_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!vld_q || out_o.ready) begin
      vld_q <= !q_stat_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= pop_data_i;
    end
  end

  assign out_o.valid           = vld_q;
  assign out_o.kind            = res_q.kind;
  assign out_o.char_out        = res_q.char_out;
  assign out_o.is_tag          = res_q.is_tag;
  assign out_o.separator       = res_q.separator;
  assign out_o.record_has_tags = res_q.record_has_tags;
  assign out_o.error_code      = res_q.error_code;
  assign out_o.last            = res_q.last;

endmodule

>>> sv/tag_list_line_tokenizer_top.sv
// top level of the tag list line tokenizer: front, result queue and output stage
// Takes one byte (or an end-of-stream mark) per input beat and returns the element
// bytes, element ends, record ends and errors it causes, in order, one result beat
// per cycle at best. The front accepts an item only while its result sequencer is
// idle; an item that causes results keeps it busy until all are pushed, including
// the held blanks and separators re-emitted from the pending store, which is read
// one entry per cycle unless the queue is full. After an error the block accepts
// input but gives no further result until reset. The output register and a
// two-beat queue let the output side stall without holding up the front until the
// queue fills.
module tag_list_line_tokenizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlt_in_if.sink      in_i,
  tlt_out_if.source   out_o
);
  import tlt_pkg::*;

  res_t        q_push_data, q_pop_data;
  logic        q_push, q_pop;
  queue_stat_t q_stat;
  front_stat_t f_stat;

  tlt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_data_o (q_push_data),
    .push_o      (q_push),
    .full_i      (q_stat.full),
    .stat_o      (f_stat)
  );

  tlt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .stat_o      (q_stat)
  );

  tlt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_data_i (q_pop_data),
    .q_stat_i   (q_stat),
    .pop_o      (q_pop),
    .out_o      (out_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("result pushed into full queue");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_stat.pend_cnt <= CntW'(MaxPending))
    else $error("pending count beyond store depth");

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_stat.halted && !f_stat.busy) |=> !q_push)
    else $error("result produced after halt");

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_stat.busy |-> !in_i.ready)
    else $error("input taken while results still being sequenced");

endmodule

>>> dv/tag_list_line_tokenizer_top_tb.sv
// self-checking testbench of the tag list line tokenizer top level with its own tokenizer model
module tag_list_line_tokenizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlt_pkg::*;

  localparam int unsigned NumDirected = 26;
  localparam int unsigned RandomItems = 220;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned DrainCycles = 40;

  localparam logic [2:0] ScanLead  = 3'd0;
  localparam logic [2:0] ScanElem  = 3'd1;
  localparam logic [2:0] ScanBlank = 3'd2;
  localparam logic [2:0] ScanSeps  = 3'd3;
  localparam logic [2:0] ScanTrail = 3'd4;

  typedef struct packed {
    logic [2:0]                 scan;
    logic [1:0]                 held;
    logic [MaxPending-1:0][1:0] pend;
    logic [CntW-1:0]            cnt;
    logic                       tag_sec;
    logic                       items;
    logic                       tags;
    logic                       halted;
  } tok_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       typed;
    logic       has_res;
    res_t       res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tlt_in_if  in_if ();
  tlt_out_if out_if ();

  tag_list_line_tokenizer_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  tok_state_t tok;
  res_t       step_res[$];
  res_t       tokens_due[$];
  stim_row_t  directed_rows [NumDirected];

  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned rnd_items;
  int unsigned mismatches;
  int unsigned cycle_count;
  logic [2:0]  final_code;

  res_t       got_beat;
  res_t       want_beat;
  logic [6:0] bad;

  function automatic res_t beat(logic [1:0] kind, logic [7:0] ch, logic tag,
                                logic [1:0] sep, logic rht, logic [2:0] err);
    res_t r;
    r.kind            = kind;
    r.char_out        = ch;
    r.is_tag          = tag;
    r.separator       = sep;
    r.record_has_tags = rht;
    r.error_code      = err;
    r.last            = 1'b1;
    return r;
  endfunction

  function automatic void put(logic [1:0] kind, logic [7:0] ch, logic tag,
                              logic [1:0] sep, logic rht, logic [2:0] err);
    res_t r;
    r      = beat(kind, ch, tag, sep, rht, err);
    r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic logic is_sep(logic [7:0] c);
    return (c == ChColon) || (c == ChComma);
  endfunction

  function automatic void halt_with(logic [2:0] err);
    put(KindErr, 8'h00, 1'b0, SepNone, 1'b0, err);
    tok.halted = 1'b1;
  endfunction

  function automatic void drop_elem();
    tok.scan = ScanLead;
    tok.held = SepNone;
    tok.cnt  = '0;
  endfunction

  function automatic void hold_char(logic [7:0] c);
    logic [1:0] code;
    if (tok.cnt >= MaxPending) begin
      halt_with(ErrOverflow);
    end else begin
      if (c == ChSpace) begin
        code = PendSpace;
      end else if (c == ChTab) begin
        code = PendTab;
      end else if (c == ChColon) begin
        code = PendColon;
      end else begin
        code = PendComma;
      end
      tok.pend[tok.cnt] = code;
      tok.cnt = tok.cnt + 1'b1;
    end
  endfunction

  function automatic void flush_with(logic [7:0] c);
    logic [7:0] ch;
    for (int i = 0; i < tok.cnt; i++) begin
      case (tok.pend[i])
        PendSpace: ch = ChSpace;
        PendTab:   ch = ChTab;
        PendColon: ch = ChColon;
        default:   ch = ChComma;
      endcase
      put(KindByte, ch, tok.tag_sec, SepNone, 1'b0, ErrNone);
    end
    tok.cnt = '0;
    put(KindByte, c, tok.tag_sec, SepNone, 1'b0, ErrNone);
    tok.held = SepNone;
    tok.scan = ScanElem;
  endfunction

  function automatic void close_elem(logic [1:0] sep);
    put(KindEnd, 8'h00, tok.tag_sec, sep, 1'b0, ErrNone);
    if (tok.tag_sec) begin
      tok.tags = 1'b1;
    end else begin
      tok.items = 1'b1;
    end
    drop_elem();
    if (sep == SepColon) begin
      if (tok.tag_sec) begin
        halt_with(ErrColon2);
      end else begin
        tok.tag_sec = 1'b1;
      end
    end
  endfunction

  function automatic void close_line();
    if (tok.scan != ScanLead) close_elem(SepNone);
    if (tok.halted) return;
    if (tok.items || tok.tags) begin
      if (!tok.items) begin
        halt_with(ErrNoItems);
        return;
      end
      put(KindRec, 8'h00, 1'b0, SepNone, tok.tags, ErrNone);
    end
    drop_elem();
    tok.tag_sec = 1'b0;
    tok.items   = 1'b0;
    tok.tags    = 1'b0;
  endfunction

  function automatic void start_elem(logic [7:0] c);
    if (is_blank(c)) return;
    if (is_sep(c)) begin
      halt_with(ErrLeadSep);
      return;
    end
    put(KindByte, c, tok.tag_sec, SepNone, 1'b0, ErrNone);
    tok.scan = ScanElem;
  endfunction

  // next state of the tokenizer and the result beats of one input beat
  function automatic void tokenize(logic [7:0] c, logic eos);
    res_t r;
    step_res.delete();
    if (tok.halted) return;
    if (eos) begin
      close_line();
    end else if (c == ChNewline) begin
      if (tok.held == SepComma) begin
        halt_with(ErrSepEnds);
      end else begin
        close_line();
      end
    end else begin
      case (tok.scan)
        ScanElem: begin
          if (is_blank(c)) begin
            hold_char(c);
            if (!tok.halted) tok.scan = ScanBlank;
          end else if (is_sep(c)) begin
            tok.held = (c == ChComma) ? SepComma : SepColon;
            hold_char(c);
            if (!tok.halted) tok.scan = ScanSeps;
          end else begin
            put(KindByte, c, tok.tag_sec, SepNone, 1'b0, ErrNone);
          end
        end
        ScanBlank: begin
          if (is_blank(c)) begin
            hold_char(c);
          end else if (is_sep(c)) begin
            tok.held = (c == ChComma) ? SepComma : SepColon;
            tok.scan = ScanTrail;
          end else begin
            flush_with(c);
          end
        end
        ScanSeps: begin
          if (is_blank(c)) begin
            if (tok.cnt > 1) begin
              halt_with(ErrDoubleSep);
            end else begin
              tok.scan = ScanTrail;
            end
          end else if (is_sep(c)) begin
            hold_char(c);
          end else begin
            flush_with(c);
          end
        end
        ScanTrail: begin
          if (!is_blank(c)) begin
            close_elem(tok.held);
            if (!tok.halted) start_elem(c);
          end
        end
        default: begin
          start_elem(c);
        end
      endcase
    end
    if (step_res.size() > 0) begin
      r      = step_res.pop_back();
      r.last = 1'b1;
      step_res.push_back(r);
    end
  endfunction

  function automatic logic would_halt(logic [7:0] c, logic eos);
    tok_state_t saved;
    logic       stops;
    saved = tok;
    tokenize(c, eos);
    stops = tok.halted;
    tok   = saved;
    step_res.delete();
    return stops;
  endfunction

  function automatic stim_row_t pred(logic [7:0] c, logic eos);
    stim_row_t row;
    row.ch      = c;
    row.eos     = eos;
    row.typed   = 1'b0;
    row.has_res = 1'b0;
    row.res     = '0;
    return row;
  endfunction

  function automatic stim_row_t quiet(logic [7:0] c, logic eos);
    stim_row_t row;
    row       = pred(c, eos);
    row.typed = 1'b1;
    return row;
  endfunction

  function automatic stim_row_t lone(logic [7:0] c, res_t r);
    stim_row_t row;
    row         = pred(c, 1'b0);
    row.typed   = 1'b1;
    row.has_res = 1'b1;
    row.res     = r;
    return row;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (is_blank(c) || is_sep(c) || (c == ChNewline));
    return c;
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? ChSpace : ChTab;
  endfunction

  function automatic logic [7:0] pick_sep();
    return $urandom_range(0, 1) ? ChComma : ChColon;
  endfunction

  function automatic logic [7:0] random_char();
    logic [7:0] c;
    case ($urandom_range(0, 17))
      0, 1, 2, 3, 4, 5: c = plain_char();
      6, 7, 8, 9, 10:   c = pick_blank();
      11, 12, 13, 14:   c = pick_sep();
      default:          c = ChNewline;
    endcase
    return c;
  endfunction

  task automatic drive_beat(logic [7:0] c, logic eos);
    while ($urandom_range(0, 99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.char_in       <= c;
    in_if.end_of_stream <= eos;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    beats_in++;
  endtask

  task automatic run_row(stim_row_t row);
    drive_beat(row.ch, row.eos);
    tokenize(row.ch, row.eos);
    if (row.typed) begin
      if (row.has_res) tokens_due.push_back(row.res);
    end else begin
      foreach (step_res[i]) tokens_due.push_back(step_res[i]);
    end
  endtask

  // errors halt the block for good, so random beats that would raise one are replaced
  task automatic send_safe(logic [7:0] c, logic eos);
    logic [7:0] ch;
    logic [7:0] alt;
    logic       stop;
    ch   = c;
    stop = eos;
    if (would_halt(ch, stop)) begin
      alt = plain_char();
      if (!would_halt(alt, 1'b0)) begin
        ch   = alt;
        stop = 1'b0;
      end else begin
        stop = 1'b1;
      end
    end
    run_row(pred(ch, stop));
    rnd_items++;
  endtask

  task automatic send_blanks(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_safe(pick_blank(), 1'b0);
  endtask

  task automatic send_element();
    int unsigned segs;
    int unsigned n;
    segs = $urandom_range(1, 3);
    for (int unsigned s = 0; s < segs; s++) begin
      if (s > 0) begin
        case ($urandom_range(0, 5))
          0, 1: begin
            send_blanks(($urandom_range(0, 6) == 0) ? MaxPending : $urandom_range(1, 3));
          end
          2, 3: begin
            n = ($urandom_range(0, 8) == 0) ? MaxPending : $urandom_range(1, 3);
            for (int unsigned i = 0; i < n; i++) send_safe(pick_sep(), 1'b0);
          end
          default: begin
          end
        endcase
      end
      n = $urandom_range(1, 3);
      for (int unsigned i = 0; i < n; i++) send_safe(plain_char(), 1'b0);
    end
  endtask

  task automatic send_list(logic [7:0] lead_sep);
    int unsigned n;
    if (lead_sep != ChNewline) begin
      send_blanks($urandom_range(0, 1));
      send_safe(lead_sep, 1'b0);
      send_blanks($urandom_range(0, 2));
    end
    n = $urandom_range(1, 3);
    for (int unsigned i = 0; i < n; i++) begin
      if (i > 0) begin
        send_blanks($urandom_range(0, 1));
        send_safe(ChComma, 1'b0);
        send_blanks($urandom_range(0, 2));
      end
      send_element();
    end
  endtask

  task automatic send_line();
    send_blanks($urandom_range(0, 2));
    send_list(ChNewline);
    if ($urandom_range(0, 1)) send_list(ChColon);
    send_blanks($urandom_range(0, 2));
    if ($urandom_range(0, 4) == 0) begin
      send_safe(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_safe(ChNewline, 1'b0);
    end
  endtask

  always @(posedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_beat = {out_if.kind, out_if.char_out, out_if.is_tag, out_if.separator,
                  out_if.record_has_tags, out_if.error_code, out_if.last};
      beats_out++;
      if (tokens_due.size() == 0) begin
        $display("%0t: result beat with none due: k%0d c%h t%0d s%0d r%0d e%0d l%0d",
                 $time, got_beat.kind, got_beat.char_out, got_beat.is_tag,
                 got_beat.separator, got_beat.record_has_tags, got_beat.error_code,
                 got_beat.last);
        mismatches++;
      end else begin
        want_beat = tokens_due.pop_front();
        bad = {got_beat.kind !== want_beat.kind,
               got_beat.char_out !== want_beat.char_out,
               got_beat.is_tag !== want_beat.is_tag,
               got_beat.separator !== want_beat.separator,
               got_beat.record_has_tags !== want_beat.record_has_tags,
               got_beat.error_code !== want_beat.error_code,
               got_beat.last !== want_beat.last};
        if (|bad) begin
          $display("%0t: field error %b exp k%0d c%h t%0d s%0d r%0d e%0d l%0d",
                   $time, bad, want_beat.kind, want_beat.char_out, want_beat.is_tag,
                   want_beat.separator, want_beat.record_has_tags, want_beat.error_code,
                   want_beat.last);
          $display("%0t:                 got k%0d c%h t%0d s%0d r%0d e%0d l%0d",
                   $time, got_beat.kind, got_beat.char_out, got_beat.is_tag,
                   got_beat.separator, got_beat.record_has_tags, got_beat.error_code,
                   got_beat.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tag_list_line_tokenizer_top: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned k;
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.char_in        = 8'h00;
    in_if.end_of_stream  = 1'b0;
    out_if.ready         = 1'b0;
    send_idle            = 24;
    recv_idle            = 69;
    beats_in             = 0;
    beats_out            = 0;
    rnd_items            = 0;
    mismatches           = 0;
    cycle_count          = 0;
    tok                  = '0;
    directed_rows = '{
      quiet(ChSpace, 1'b0),
      lone(8'h00, beat(KindByte, 8'h00, 1'b0, SepNone, 1'b0, ErrNone)),
      lone(8'hff, beat(KindByte, 8'hff, 1'b0, SepNone, 1'b0, ErrNone)),
      quiet(ChTab, 1'b0),
      quiet(ChSpace, 1'b0),
      pred("x", 1'b0),
      quiet(ChComma, 1'b0),
      quiet(ChComma, 1'b0),
      pred("y", 1'b0),
      quiet(ChComma, 1'b0),
      quiet(ChSpace, 1'b0),
      quiet(ChTab, 1'b0),
      pred("b", 1'b0),
      quiet(ChColon, 1'b0),
      quiet(ChSpace, 1'b0),
      pred("t", 1'b0),
      quiet(ChSpace, 1'b0),
      pred(ChNewline, 1'b0),
      quiet(ChNewline, 1'b0),
      lone("q", beat(KindByte, "q", 1'b0, SepNone, 1'b0, ErrNone)),
      quiet(ChColon, 1'b0),
      pred(ChNewline, 1'b0),
      lone("r", beat(KindByte, "r", 1'b0, SepNone, 1'b0, ErrNone)),
      quiet(ChSpace, 1'b0),
      pred(8'hff, 1'b1),
      quiet(8'h3c, 1'b1)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) run_row(directed_rows[i]);

    while (rnd_items < RandomItems) begin
      if (rnd_items >= 2 * RandomItems / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (rnd_items >= RandomItems / 3) begin
        send_idle = 69;
        recv_idle = 24;
      end
      if ($urandom_range(0, 9) < 7) begin
        send_line();
      end else begin
        k = $urandom_range(1, 6);
        for (int unsigned i = 0; i < k; i++) begin
          send_safe(random_char(), $urandom_range(0, 9) == 0);
        end
      end
    end

    // one error per run, since it holds until reset
    run_row(pred(8'($urandom_range(0, 255)), 1'b1));
    case ($urandom_range(0, 4))
      0: begin
        final_code = ErrSepEnds;
        run_row(pred("a", 1'b0));
        run_row(pred(ChComma, 1'b0));
        run_row(lone(ChNewline, beat(KindErr, 8'h00, 1'b0, SepNone, 1'b0, ErrSepEnds)));
      end
      1: begin
        final_code = ErrLeadSep;
        run_row(lone(pick_sep(), beat(KindErr, 8'h00, 1'b0, SepNone, 1'b0, ErrLeadSep)));
      end
      2: begin
        final_code = ErrDoubleSep;
        run_row(pred("a", 1'b0));
        run_row(pred(ChComma, 1'b0));
        run_row(pred(ChComma, 1'b0));
        run_row(lone(ChSpace, beat(KindErr, 8'h00, 1'b0, SepNone, 1'b0, ErrDoubleSep)));
      end
      3: begin
        final_code = ErrColon2;
        run_row(pred("a", 1'b0));
        run_row(pred(ChColon, 1'b0));
        run_row(pred(ChSpace, 1'b0));
        run_row(pred("b", 1'b0));
        run_row(pred(ChColon, 1'b0));
        run_row(pred(ChSpace, 1'b0));
        run_row(pred("c", 1'b0));
      end
      default: begin
        final_code = ErrOverflow;
        run_row(pred("a", 1'b0));
        for (int unsigned i = 0; i < MaxPending; i++) run_row(pred(pick_blank(), 1'b0));
        run_row(lone(ChSpace, beat(KindErr, 8'h00, 1'b0, SepNone, 1'b0, ErrOverflow)));
      end
    endcase
    for (int unsigned i = 0; i < 6; i++) begin
      run_row(pred(random_char(), $urandom_range(0, 3) == 0));
    end
    in_if.valid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d directed rows and %0d random bytes or end marks, %0d input beats in all",
             NumDirected, rnd_items, beats_in);
    $display("%0d result beats checked, run closed by error code %0d and silence after it",
             beats_out, final_code);
    if (mismatches == 0) begin
      $display("tag_list_line_tokenizer_top: match");
    end else begin
      $display("tag_list_line_tokenizer_top: mismatch");
    end
    $finish;
  end

endmodule
